// ===== hdl/tsc_pkg.sv =====
// Package with shared constants and command and status types for the slope coherence block.
`default_nettype none
package tsc_pkg;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_WINDOW_DEF = 256;
    localparam int SUM_W = 48;
    localparam int OUT_W = 16;
    localparam int PROD2_W = 2 * SUM_W;
    localparam int NUM_W = SUM_W + 8;
    localparam int COH_Q_W = 33;
    localparam int CNT_W = 6;
    localparam int MUL_STEPS = SUM_W;
    localparam int SL_STEPS = NUM_W;
    localparam int CO_STEPS = COH_Q_W;
    localparam int SQ_STEPS = OUT_W;

    typedef struct packed {
        logic load;
        logic pair;
        logic acc;
        logic mul_init;
        logic mul_sel;
        logic mul_step;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic finish;
    } tsc_cmd_t;

    typedef struct packed {
        logic last;
        logic zero_energy;
        logic out_busy;
    } tsc_stat_t;
endpackage
`default_nettype wire

// ===== hdl/tsc_if.sv =====
// Valid/ready channel interfaces for the sample words and the result words.
`default_nettype none
interface tsc_in_if #(parameter int SAMPLE_BITS = 16);
    logic valid;
    logic ready;
    logic signed [SAMPLE_BITS-1:0] sample_a;
    logic signed [SAMPLE_BITS-1:0] sample_b;
    logic last;
    modport source (output valid, sample_a, sample_b, last, input ready);
    modport sink (input valid, sample_a, sample_b, last, output ready);
endinterface

interface tsc_out_if;
    logic valid;
    logic ready;
    logic signed [15:0] slope;
    logic [15:0] coherence;
    modport source (output valid, slope, coherence, input ready);
    modport sink (input valid, slope, coherence, output ready);
endinterface
`default_nettype wire

// ===== hdl/tsc_ctrl.sv =====
// Controller state machine that sequences sample accumulation and the end-of-window math.
`default_nettype none
module tsc_ctrl
    import tsc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire tsc_stat_t stat,
    output tsc_cmd_t       cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_PAIR, S_ACC, S_CHK, S_MUL_SQ, S_MUL2I, S_MUL_TX,
        S_DSI, S_DIV_SL, S_DCI, S_DIV_CO, S_SQI, S_SQRT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                cmd.pair = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc = 1'b1;
                state_next = stat.last ? S_CHK : S_IDLE;
            end
            S_CHK:
            begin
                if (stat.zero_energy)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.mul_init = 1'b1;
                    cnt_next = CNT_W'(MUL_STEPS - 1);
                    state_next = S_MUL_SQ;
                end
            end
            S_MUL_SQ:
            begin
                cmd.mul_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_MUL2I;
                end
            end
            S_MUL2I:
            begin
                cmd.mul_init = 1'b1;
                cmd.mul_sel = 1'b1;
                cnt_next = CNT_W'(MUL_STEPS - 1);
                state_next = S_MUL_TX;
            end
            S_MUL_TX:
            begin
                cmd.mul_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DSI;
                end
            end
            S_DSI:
            begin
                cmd.div_init = 1'b1;
                cnt_next = CNT_W'(SL_STEPS - 1);
                state_next = S_DIV_SL;
            end
            S_DIV_SL:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DCI;
                end
            end
            S_DCI:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel = 1'b1;
                cnt_next = CNT_W'(CO_STEPS - 1);
                state_next = S_DIV_CO;
            end
            S_DIV_CO:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SQI;
                end
            end
            S_SQI:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next = CNT_W'(SQ_STEPS - 1);
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/tsc_dp.sv =====
// Datapath with the window sums, serial multiplier, serial divider and root search.
`default_nettype none
module tsc_dp
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tsc_cmd_t                      cmd,
    output tsc_stat_t                          stat,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_a,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_b,
    input  wire logic                          last,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [OUT_W-1:0]            slope,
    output logic [OUT_W-1:0]                   coherence
);
    localparam int D_W = SAMPLE_BITS + 2;
    localparam int P_W = 2 * D_W;
    localparam int EXT_W = ((P_W > SUM_W) ? P_W : SUM_W) + 2;
    localparam int PC_W = $clog2(MAX_WINDOW);
    localparam logic [PC_W-1:0] PC_LIMIT = PC_W'(MAX_WINDOW - 1);
    localparam logic signed [EXT_W-1:0] XT_MAX = EXT_W'((64'sd1 <<< (SUM_W - 1)) - 1);
    localparam logic signed [EXT_W-1:0] XT_MIN = -XT_MAX - 1;
    localparam logic [EXT_W-1:0] SQ_MAX = EXT_W'((64'd1 << SUM_W) - 1);
    localparam logic [OUT_W-1:0] COH_SAT = '1;

    logic signed [SAMPLE_BITS-1:0] a_reg, b_reg, pa_reg, pb_reg;
    logic last_reg, have_prev_reg, pvalid_reg;
    logic [PC_W-1:0] pcnt_reg;
    logic signed [P_W-1:0] pxt_reg, ptt_reg, pxx_reg;
    logic signed [SUM_W-1:0] xt_reg;
    logic [SUM_W-1:0] tt_reg, xx_reg;
    logic [PROD2_W-1:0] acc_reg, sq_reg;
    logic [SUM_W-1:0] mcand_reg, mplier_reg;
    logic [PROD2_W:0] rem_reg;
    logic [PROD2_W-1:0] den_reg;
    logic [NUM_W-1:0] num_reg, quo_reg;
    logic ovf_reg, sat_reg;
    logic signed [OUT_W-1:0] slope_reg;
    logic [31:0] q_reg;
    logic [OUT_W-1:0] k_reg, sbit_reg;
    logic out_valid_reg;

    logic signed [D_W-1:0] dx, dt;
    logic signed [EXT_W-1:0] xt_sum;
    logic [EXT_W-1:0] tt_sum, xx_sum;
    logic [SUM_W-1:0] mag;
    logic [PROD2_W:0] div_t, div_d;
    logic div_ge;
    logic [OUT_W-1:0] sq_c;
    logic [31:0] sq_cc;
    logic signed [OUT_W-1:0] slope_calc;

    assign stat.last = last_reg;
    assign stat.zero_energy = (tt_reg == '0) || (xx_reg == '0);
    assign stat.out_busy = out_valid_reg && !out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        dx = (D_W'(pb_reg) - D_W'(pa_reg)) + (D_W'(b_reg) - D_W'(a_reg));
        dt = (D_W'(a_reg) - D_W'(pa_reg)) + (D_W'(b_reg) - D_W'(pb_reg));
        xt_sum = EXT_W'(xt_reg) + EXT_W'(pxt_reg);
        tt_sum = EXT_W'(tt_reg) + EXT_W'($unsigned(ptt_reg));
        xx_sum = EXT_W'(xx_reg) + EXT_W'($unsigned(pxx_reg));
        mag = xt_reg[SUM_W-1] ? SUM_W'(-xt_reg) : SUM_W'(xt_reg);
        div_t = {rem_reg[PROD2_W-1:0], num_reg[NUM_W-1]};
        div_d = {1'b0, den_reg};
        div_ge = div_t >= div_d;
        sq_c = k_reg | sbit_reg;
        sq_cc = 32'(sq_c) * 32'(sq_c);
        if (xt_reg > 0)
        begin
            slope_calc = (quo_reg > NUM_W'(32768)) ? OUT_W'(-32768)
                                                   : OUT_W'(-quo_reg);
        end
        else
        begin
            slope_calc = (quo_reg > NUM_W'(32767)) ? OUT_W'(32767) : OUT_W'(quo_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= sample_a;
            b_reg <= sample_b;
            last_reg <= last;
        end
        if (cmd.pair)
        begin
            pxt_reg <= P_W'(dt) * P_W'(dx);
            ptt_reg <= P_W'(dt) * P_W'(dt);
            pxx_reg <= P_W'(dx) * P_W'(dx);
        end
        if (cmd.mul_init)
        begin
            acc_reg <= '0;
            if (cmd.mul_sel)
            begin
                sq_reg <= acc_reg;
                mcand_reg <= tt_reg;
                mplier_reg <= xx_reg;
            end
            else
            begin
                mcand_reg <= mag;
                mplier_reg <= mag;
            end
        end
        else if (cmd.mul_step)
        begin
            acc_reg <= {acc_reg[PROD2_W-2:0], 1'b0}
                       + (mplier_reg[SUM_W-1] ? PROD2_W'(mcand_reg) : '0);
            mplier_reg <= {mplier_reg[SUM_W-2:0], 1'b0};
        end
        if (cmd.div_init)
        begin
            quo_reg <= '0;
            if (cmd.div_sel)
            begin
                slope_reg <= slope_calc;
                rem_reg <= (PROD2_W + 1)'(sq_reg >> 1);
                den_reg <= acc_reg;
                ovf_reg <= (sq_reg >> 1) >= acc_reg;
                num_reg <= {sq_reg[0], {(NUM_W - 1){1'b0}}};
            end
            else
            begin
                rem_reg <= '0;
                den_reg <= PROD2_W'(tt_reg);
                num_reg <= (NUM_W'(mag) << 8) + NUM_W'(tt_reg >> 1);
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? (div_t - div_d) : div_t;
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[NUM_W-2:0], div_ge};
        end
        if (cmd.sqrt_init)
        begin
            q_reg <= quo_reg[31:0];
            sat_reg <= ovf_reg || quo_reg[32];
            k_reg <= '0;
            sbit_reg <= {1'b1, {(OUT_W - 1){1'b0}}};
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_cc <= q_reg)
            begin
                k_reg <= sq_c;
            end
            sbit_reg <= sbit_reg >> 1;
        end
        if (cmd.finish)
        begin
            if (stat.zero_energy)
            begin
                slope <= '0;
                coherence <= '0;
            end
            else
            begin
                slope <= slope_reg;
                coherence <= sat_reg ? COH_SAT : k_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= '0;
            pb_reg <= '0;
            have_prev_reg <= 1'b0;
            pvalid_reg <= 1'b0;
            pcnt_reg <= '0;
            xt_reg <= '0;
            tt_reg <= '0;
            xx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pair)
            begin
                pvalid_reg <= have_prev_reg && (pcnt_reg < PC_LIMIT);
            end
            if (cmd.acc)
            begin
                pa_reg <= a_reg;
                pb_reg <= b_reg;
                have_prev_reg <= 1'b1;
                if (pvalid_reg)
                begin
                    pcnt_reg <= pcnt_reg + 1'b1;
                    if (xt_sum > XT_MAX)
                    begin
                        xt_reg <= SUM_W'(XT_MAX);
                    end
                    else if (xt_sum < XT_MIN)
                    begin
                        xt_reg <= SUM_W'(XT_MIN);
                    end
                    else
                    begin
                        xt_reg <= SUM_W'(xt_sum);
                    end
                    tt_reg <= (tt_sum > SQ_MAX) ? SUM_W'(SQ_MAX) : SUM_W'(tt_sum);
                    xx_reg <= (xx_sum > SQ_MAX) ? SUM_W'(SQ_MAX) : SUM_W'(xx_sum);
                end
            end
            if (cmd.finish)
            begin
                have_prev_reg <= 1'b0;
                pcnt_reg <= '0;
                xt_reg <= '0;
                tt_reg <= '0;
                xx_reg <= '0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/two_trace_slope_coherence.sv =====
// Top level of the two-trace slope and coherence estimator.
`default_nettype none
// Takes one sample word (a neighbor-trace sample and a test-trace sample) while
// a window is open, pairs and accumulates it, and only then takes the next. On
// the word marked last it computes the slope and coherence and offers one result
// word. That end-of-window work runs through one serial 48-bit multiplier twice,
// one serial divider for the slope and for the coherence ratio, and a 16-step
// root search; a window with no energy skips it. The result sits in an output
// register, so a new window may begin while the last result waits to be taken.
module two_trace_slope_coherence
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    tsc_in_if.sink    samples,
    tsc_out_if.source results
);
    tsc_cmd_t cmd;
    tsc_stat_t stat;

    tsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsc_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample_a  (samples.sample_a),
        .sample_b  (samples.sample_b),
        .last      (samples.last),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .slope     (results.slope),
        .coherence (results.coherence)
    );
endmodule
`default_nettype wire

// ===== hdl/tsc_chk.sv =====
// Port checker for the slope coherence block and its bind to the top level.
`default_nettype none
module tsc_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_last,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] slope,
    input wire logic [15:0] coherence
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slope) && $stable(coherence))
        else $error("result word changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("sample word withdrawn while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample word taken on consecutive cycles");

    a_result_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last && !out_valid |=> !out_valid)
        else $error("result word appeared after a sample word that was not last");
endmodule

bind two_trace_slope_coherence tsc_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_last   (samples.last),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .slope     (results.slope),
    .coherence (results.coherence)
);
`default_nettype wire
